@@ rtl/lsps_pkg.sv @@
package lsps_pkg;

    localparam int UPC_W = 3;
    localparam int ERR_W = 11;
    localparam int INT_W = 16;
    localparam int ACC_W = 26;
    localparam int MOP_W = 17;

    localparam logic [7:0] BASE_RST = 8'd190;
    localparam logic [7:0] KP_RST   = 8'd20;
    localparam logic [7:0] KI_RST   = 8'd5;
    localparam logic [7:0] KD_RST   = 8'd20;
    localparam logic [7:0] DUTY_MAX = 8'd255;

    localparam logic signed [INT_W:0] INT_LIMIT = 17'sd32767;

    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_KP   = 2'd1;
    localparam logic [1:0] REG_KI   = 2'd2;
    localparam logic [1:0] REG_KD   = 2'd3;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd2;

    localparam logic [1:0] MODE_PID  = 2'd0;
    localparam logic [1:0] MODE_SPIN = 2'd1;
    localparam logic [1:0] MODE_HOLD = 2'd2;

    localparam logic [UPC_W-1:0] UPC_FETCH = 3'd0;
    localparam logic [UPC_W-1:0] UPC_PTERM = 3'd1;
    localparam logic [UPC_W-1:0] UPC_INTEG = 3'd2;
    localparam logic [UPC_W-1:0] UPC_ITERM = 3'd3;
    localparam logic [UPC_W-1:0] UPC_DTERM = 3'd4;
    localparam logic [UPC_W-1:0] UPC_EMITP = 3'd5;
    localparam logic [UPC_W-1:0] UPC_EMITS = 3'd6;

    typedef enum logic [1:0] {
        MS_P,
        MS_I,
        MS_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_PID,
        EM_SPIN
    } emit_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_WAIT_IN,
        JC_DARK,
        JC_EMIT
    } jump_t;

    typedef struct packed {
        logic             take_in;
        mul_sel_t         mul_sel;
        acc_op_t          acc_op;
        logic             integ_en;
        emit_t            emit;
        jump_t            cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_t w;
        w = '{take_in: 1'b0, mul_sel: MS_P, acc_op: ACC_HOLD, integ_en: 1'b0,
              emit: EM_NONE, cond: JC_EMIT, target: UPC_FETCH};
        case (upc)
            UPC_FETCH:
            begin
                w.take_in = 1'b1;
                w.cond    = JC_WAIT_IN;
            end
            UPC_PTERM:
            begin
                w.mul_sel = MS_P;
                w.acc_op  = ACC_LOAD;
                w.cond    = JC_DARK;
                w.target  = UPC_EMITS;
            end
            UPC_INTEG:
            begin
                w.integ_en = 1'b1;
                w.cond     = JC_NEXT;
            end
            UPC_ITERM:
            begin
                w.mul_sel = MS_I;
                w.acc_op  = ACC_ADD;
                w.cond    = JC_NEXT;
            end
            UPC_DTERM:
            begin
                w.mul_sel = MS_D;
                w.acc_op  = ACC_ADD;
                w.cond    = JC_NEXT;
            end
            UPC_EMITP:
            begin
                w.emit = EM_PID;
            end
            UPC_EMITS:
            begin
                w.emit = EM_SPIN;
            end
            default:
            begin
                w.cond = JC_EMIT;
            end
        endcase
        return w;
    endfunction

    // Q8 error: floor(weighted sum * 256 / lit count) - 768
    function automatic logic signed [ERR_W-1:0] error_lut(input logic [4:0] bits);
        logic signed [ERR_W-1:0] e;
        case (bits)
            5'd1:    e = -11'sd512;
            5'd2:    e = -11'sd256;
            5'd3:    e = -11'sd384;
            5'd4:    e =  11'sd0;
            5'd5:    e = -11'sd256;
            5'd6:    e = -11'sd128;
            5'd7:    e = -11'sd256;
            5'd8:    e =  11'sd256;
            5'd9:    e = -11'sd128;
            5'd10:   e =  11'sd0;
            5'd11:   e = -11'sd171;
            5'd12:   e =  11'sd128;
            5'd13:   e = -11'sd86;
            5'd14:   e =  11'sd0;
            5'd15:   e = -11'sd128;
            5'd16:   e =  11'sd512;
            5'd17:   e =  11'sd0;
            5'd18:   e =  11'sd128;
            5'd19:   e = -11'sd86;
            5'd20:   e =  11'sd256;
            5'd21:   e =  11'sd0;
            5'd22:   e =  11'sd85;
            5'd23:   e = -11'sd64;
            5'd24:   e =  11'sd384;
            5'd25:   e =  11'sd85;
            5'd26:   e =  11'sd170;
            5'd27:   e =  11'sd0;
            5'd28:   e =  11'sd256;
            5'd29:   e =  11'sd64;
            5'd30:   e =  11'sd128;
            5'd31:   e =  11'sd0;
            default: e =  11'sd0;
        endcase
        return e;
    endfunction

endpackage

@@ rtl/line_sensor_pid_steering_core.sv @@
// Channel  Signals                                      Direction
// in       in_valid, in_ready, sensor_bits              request in
// out      out_valid, out_ready, left_duty, right_duty,
//          left_reverse, right_reverse, drive_mode      request out
// cfg      cfg_we, cfg_index, cfg_data                  write only
//
// A sample on the line steps through fetch, P, integral, I, D and emit; a dark
// sample steps through fetch, P and emit. One shared 9x17 multiplier serves P, I and D in turn.
// in_ready is high only at the fetch step; it does not wait for the output.
// The emit step holds while the output register is full and not taken.
// Reset restores the default gains and clears the error, integral and side state.
module line_sensor_pid_steering_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  sensor_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  left_duty,
    output logic [7:0]  right_duty,
    output logic        left_reverse,
    output logic        right_reverse,
    output logic [1:0]  drive_mode,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lsps_pkg::*;

    logic [7:0] base_reg, kp_reg, ki_reg, kd_reg;

    logic [UPC_W-1:0] upc_reg, upc_next;
    ucode_t           uw;

    logic signed [ERR_W-1:0] cur_reg, cur_next;
    logic signed [ERR_W-1:0] prev_reg, prev_next;
    logic signed [INT_W-1:0] integ_reg, integ_next;
    logic [1:0]              side_reg, side_next;
    logic                    dark_reg, dark_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] ldut_reg, ldut_next, rdut_reg, rdut_next;
    logic       lrev_reg, lrev_next, rrev_reg, rrev_next;
    logic [1:0] mode_reg, mode_next;

    logic                    accept, busy;
    logic signed [8:0]       mul_gain;
    logic signed [MOP_W-1:0] mul_op;
    logic signed [ACC_W-1:0] prod;
    logic signed [INT_W:0]   integ_sum;
    logic signed [17:0]      corr;
    logic signed [18:0]      lraw, rraw;

    assign uw       = ucode_rom(upc_reg);
    assign in_ready = uw.take_in;
    assign accept   = in_valid && uw.take_in;
    assign busy     = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RST;
            kp_reg   <= KP_RST;
            ki_reg   <= KI_RST;
            kd_reg   <= KD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE: base_reg <= cfg_data;
                REG_KP:   kp_reg   <= cfg_data;
                REG_KI:   ki_reg   <= cfg_data;
                REG_KD:   kd_reg   <= cfg_data;
                default:  base_reg <= base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (uw.cond)
            JC_WAIT_IN: upc_next = in_valid ? UPC_W'(upc_reg + 1'b1) : upc_reg;
            JC_DARK:    upc_next = dark_reg ? uw.target : UPC_W'(upc_reg + 1'b1);
            JC_EMIT:    upc_next = busy ? upc_reg : uw.target;
            default:    upc_next = UPC_W'(upc_reg + 1'b1);
        endcase
    end

    always_comb
    begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        side_next = side_reg;
        dark_next = dark_reg;
        if (accept)
        begin
            prev_next = cur_reg;
            dark_next = (sensor_bits == 5'd0);
            if (sensor_bits != 5'd0)
                cur_next = error_lut(sensor_bits);
            if (sensor_bits[4])
                side_next = SIDE_LEFT;
            else if (sensor_bits[0])
                side_next = SIDE_RIGHT;
        end
    end

    always_comb
    begin
        case (uw.mul_sel)
            MS_I:
            begin
                mul_gain = $signed({1'b0, ki_reg});
                mul_op   = MOP_W'(integ_reg);
            end
            MS_D:
            begin
                mul_gain = $signed({1'b0, kd_reg});
                mul_op   = MOP_W'(cur_reg) - MOP_W'(prev_reg);
            end
            default:
            begin
                mul_gain = $signed({1'b0, kp_reg});
                mul_op   = MOP_W'(cur_reg);
            end
        endcase
        prod = ACC_W'(mul_gain) * ACC_W'(mul_op);
        case (uw.acc_op)
            ACC_LOAD: acc_next = prod;
            ACC_ADD:  acc_next = acc_reg + prod;
            default:  acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        integ_sum  = (INT_W + 1)'(integ_reg) + (INT_W + 1)'(cur_reg);
        integ_next = integ_reg;
        if (uw.integ_en)
        begin
            if (integ_sum > INT_LIMIT)
                integ_next = INT_LIMIT[INT_W-1:0];
            else if (integ_sum < -INT_LIMIT)
                integ_next = INT_W'(-INT_LIMIT);
            else
                integ_next = integ_sum[INT_W-1:0];
        end
    end

    always_comb
    begin
        corr = acc_reg[ACC_W-1:8];
        lraw = $signed({11'd0, base_reg}) - 19'(corr);
        rraw = $signed({11'd0, base_reg}) + 19'(corr);

        out_valid_next = out_valid_reg && !out_ready;
        ldut_next = ldut_reg;
        rdut_next = rdut_reg;
        lrev_next = lrev_reg;
        rrev_next = rrev_reg;
        mode_next = mode_reg;
        if (!busy && uw.emit != EM_NONE)
        begin
            out_valid_next = 1'b1;
            if (uw.emit == EM_PID)
            begin
                mode_next = MODE_PID;
                lrev_next = 1'b0;
                rrev_next = 1'b0;
                ldut_next = lraw[18] ? 8'd0 : (lraw > 19'sd255) ? DUTY_MAX : lraw[7:0];
                rdut_next = rraw[18] ? 8'd0 : (rraw > 19'sd255) ? DUTY_MAX : rraw[7:0];
            end
            else if (side_reg == SIDE_RIGHT || side_reg == SIDE_LEFT)
            begin
                mode_next = MODE_SPIN;
                ldut_next = DUTY_MAX;
                rdut_next = DUTY_MAX;
                lrev_next = (side_reg == SIDE_RIGHT);
                rrev_next = (side_reg == SIDE_LEFT);
            end
            else
            begin
                mode_next = MODE_HOLD;
                ldut_next = 8'd0;
                rdut_next = 8'd0;
                lrev_next = 1'b0;
                rrev_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UPC_FETCH;
            cur_reg       <= '0;
            prev_reg      <= '0;
            integ_reg     <= '0;
            side_reg      <= SIDE_NONE;
            dark_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            integ_reg     <= integ_next;
            side_reg      <= side_next;
            dark_reg      <= dark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        ldut_reg <= ldut_next;
        rdut_reg <= rdut_next;
        lrev_reg <= lrev_next;
        rrev_reg <= rrev_next;
        mode_reg <= mode_next;
    end

    assign out_valid     = out_valid_reg;
    assign left_duty     = ldut_reg;
    assign right_duty    = rdut_reg;
    assign left_reverse  = lrev_reg;
    assign right_reverse = rrev_reg;
    assign drive_mode    = mode_reg;

`ifndef ASSERT_OFF
    a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> upc_reg == UPC_PTERM)
        else $error("sequencer did not leave fetch after a request");

    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(upc_reg) == UPC_EMITP || $past(upc_reg) == UPC_EMITS)
        else $error("output raised outside an emit step");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg == UPC_FETCH && !in_valid |=> upc_reg == UPC_FETCH)
        else $error("sequencer left fetch without a request");
`endif

endmodule

@@ bench/tb_line_sensor_pid_steering_core.sv @@
module tb_line_sensor_pid_steering_core;

    import lsps_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 285;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic       left_reverse;
        logic       right_reverse;
        logic [1:0] drive_mode;
    } steer_t;

    class steering_scoreboard;
        int base_speed;
        int gain_p;
        int gain_i;
        int gain_d;
        int last_err;
        int now_err;
        int integ_sum;
        logic [1:0] edge_seen;
        steer_t expected_q[$];
        int fails;

        function new();
            base_speed = BASE_RST;
            gain_p     = KP_RST;
            gain_i     = KI_RST;
            gain_d     = KD_RST;
            last_err   = 0;
            now_err    = 0;
            integ_sum  = 0;
            edge_seen  = SIDE_NONE;
            fails      = 0;
        endfunction

        function void apply_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_BASE: base_speed = val;
                REG_KP:   gain_p = val;
                REG_KI:   gain_i = val;
                REG_KD:   gain_d = val;
                default:  ;
            endcase
        endfunction

        function logic [7:0] limit_duty(int v);
            if (v < 0)
                return 8'd0;
            if (v > DUTY_MAX)
                return DUTY_MAX;
            return v[7:0];
        endfunction

        // accepted sensor request: advance the controller and queue its drive
        function void note_request(logic [4:0] bits);
            int lit;
            int wsum;
            int acc;
            int corr;
            steer_t r;
            lit  = 0;
            wsum = 0;
            r = '{left_duty: 8'd0, right_duty: 8'd0, left_reverse: 1'b0,
                  right_reverse: 1'b0, drive_mode: MODE_HOLD};
            if (bits[0])
                edge_seen = SIDE_RIGHT;
            if (bits[4])
                edge_seen = SIDE_LEFT;
            for (int k = 0; k < 5; k++)
            begin
                if (bits[k])
                begin
                    lit++;
                    wsum += k + 1;
                end
            end
            last_err = now_err;
            if (lit == 0)
            begin
                if (edge_seen == SIDE_RIGHT)
                begin
                    r.left_duty    = DUTY_MAX;
                    r.right_duty   = DUTY_MAX;
                    r.left_reverse = 1'b1;
                    r.drive_mode   = MODE_SPIN;
                end
                else if (edge_seen == SIDE_LEFT)
                begin
                    r.left_duty     = DUTY_MAX;
                    r.right_duty    = DUTY_MAX;
                    r.right_reverse = 1'b1;
                    r.drive_mode    = MODE_SPIN;
                end
            end
            else
            begin
                now_err = (wsum * 256) / lit - 768;
                integ_sum += now_err;
                if (integ_sum > 32767)
                    integ_sum = 32767;
                if (integ_sum < -32767)
                    integ_sum = -32767;
                acc = gain_p * now_err + gain_i * integ_sum + gain_d * (now_err - last_err);
                corr = acc >>> 8;
                r.left_duty  = limit_duty(base_speed - corr);
                r.right_duty = limit_duty(base_speed + corr);
                r.drive_mode = MODE_PID;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(steer_t got);
            steer_t want;
            if (expected_q.size() == 0)
            begin
                $error("steering result with no request outstanding");
                fails++;
                return;
            end
            want = expected_q.pop_front();
            if (got.left_duty !== want.left_duty)
            begin
                $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
                fails++;
            end
            if (got.right_duty !== want.right_duty)
            begin
                $error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
                fails++;
            end
            if (got.left_reverse !== want.left_reverse)
            begin
                $error("left_reverse: expected %0d, got %0d",
                       want.left_reverse, got.left_reverse);
                fails++;
            end
            if (got.right_reverse !== want.right_reverse)
            begin
                $error("right_reverse: expected %0d, got %0d",
                       want.right_reverse, got.right_reverse);
                fails++;
            end
            if (got.drive_mode !== want.drive_mode)
            begin
                $error("drive_mode: expected %0d, got %0d", want.drive_mode, got.drive_mode);
                fails++;
            end
        endfunction
    endclass

    localparam logic [4:0] OPENING [0:19] = '{
        5'd0, 5'd1, 5'd0, 5'd16, 5'd0, 5'd17, 5'd0, 5'd31, 5'd4, 5'd8,
        5'd2, 5'd3, 5'd24, 5'd11, 5'd26, 5'd13, 5'd22, 5'd23, 5'd29, 5'd0
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [4:0] sensor_bits = 5'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic       left_reverse;
    logic       right_reverse;
    logic [1:0] drive_mode;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_BASE;
    logic [7:0] cfg_data = 8'd0;

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    logic hold_on = 1'b0;
    int  cycles = 0;

    steering_scoreboard sb = new();

    line_sensor_pid_steering_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sensor_bits   (sensor_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .left_reverse  (left_reverse),
        .right_reverse (right_reverse),
        .drive_mode    (drive_mode),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL line_sensor_pid_steering_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        steer_t got;
        if (out_valid && out_ready)
        begin
            got.left_duty     = left_duty;
            got.right_duty    = right_duty;
            got.left_reverse  = left_reverse;
            got.right_reverse = right_reverse;
            got.drive_mode    = drive_mode;
            sb.check_result(got);
        end
        out_ready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input logic [4:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sensor_bits <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(b);
    endtask

    // runs of one-sided samples drive the integral into saturation
    task automatic send_random(input int n);
        int run_left;
        int flavour;
        logic [4:0] b;
        run_left = 0;
        flavour  = 0;
        for (int k = 0; k < n; k++)
        begin
            if (run_left == 0)
            begin
                flavour  = $urandom_range(0, 3);
                run_left = $urandom_range(5, 200);
            end
            run_left--;
            case (flavour)
                0: b = 5'($urandom_range(0, 31));
                1: b = {2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)), 2'b00};
                2: b = {2'b00, 1'($urandom_range(0, 1)), 2'($urandom_range(1, 3))};
                default: b = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(0, 31));
            endcase
            if (flavour != 3 && $urandom_range(0, 9) == 0)
                b = 5'd0;
            send_item(b);
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.apply_reg(idx, val);
    endtask

    task automatic run_phase(input logic [7:0] base, input logic [7:0] kp,
                             input logic [7:0] ki, input logic [7:0] kd,
                             input int idle, input int stall, input bit squeeze);
        drain();
        write_reg(REG_BASE, base);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        cfg_we        <= 1'b0;
        send_idle_pct  = idle;
        stall_pct     <= stall;
        if (squeeze)
        begin
            fork
                begin
                    hold_on <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_on <= 1'b0;
                end
            join_none
        end
        send_random(PHASE_ITEMS);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[k])
            send_item(OPENING[k]);
        send_random(60);

        run_phase(8'd255, 8'd255, 8'd255, 8'd255, 75, 0, 1'b0);
        run_phase(8'd0, 8'd0, 8'd0, 8'd0, 0, 75, 1'b0);
        run_phase(8'd0, 8'd255, 8'd0, 8'd255, 10, 10, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 63)),
                  8'($urandom_range(0, 15)), 8'($urandom_range(0, 63)), 75, 0, 1'b0);
        run_phase(8'd128, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 75, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'd20, 8'd5, 8'd20, 10, 10, 1'b0);

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.fails == 0)
            $display("PASS line_sensor_pid_steering_core");
        else
            $display("FAIL line_sensor_pid_steering_core");
        $finish;
    end

endmodule
